>>> hw/rtl/h2r_pkg.sv
package h2r_pkg;

    // Q1.FRAC_BITS unsigned fixed point, ONE means 1.0
    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = FRAC_BITS + 1;
    localparam int Q_W       = FIELD_W + 1;
    localparam int PROD_W    = Q_W + FIELD_W;
    localparam int RAMP_W    = PROD_W - FRAC_BITS;
    localparam int NUM_CH    = 3;

    typedef logic [FIELD_W-1:0] fx_t;
    typedef logic [Q_W-1:0]     q_t;

    localparam fx_t ONE        = fx_t'(64'd1 << FRAC_BITS);
    localparam fx_t THIRD      = fx_t'((64'd1 << FRAC_BITS) / 3);
    localparam fx_t SIXTH      = fx_t'((64'd1 << FRAC_BITS) / 6);
    localparam fx_t TWO_THIRDS = fx_t'((64'd2 << FRAC_BITS) / 3);
    localparam fx_t HALF       = fx_t'((64'd1 << FRAC_BITS) / 2);
    localparam fx_t U_MAX      = fx_t'(6 * ((64'd1 << FRAC_BITS) / 6));

    // Piece of the channel ramp that a shifted hue falls on
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_PLAT,
        SEG_FALL,
        SEG_FLOOR
    } seg_t;

endpackage

>>> hw/rtl/h2r_ifs.sv
interface hsl_in_if import h2r_pkg::*; ();
    logic valid;
    logic ready;
    fx_t  hue;
    fx_t  saturation;
    fx_t  lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

interface rgb_out_if import h2r_pkg::*; ();
    logic valid;
    logic ready;
    fx_t  red;
    fx_t  green;
    fx_t  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

>>> hw/rtl/hsl_to_rgb.sv
// Channel   Dir  Payload                          Transfer
// hsl_in    in   hue, saturation, lightness (Q1.16)  valid & ready
// rgb_out   out  red, green, blue (Q1.16)            valid & ready
//
// Throughput: one pixel per cycle while the skid slot is empty. The input
// transfer loads stage 1, four more pipeline stages follow, then the output
// register drives rgb_out.valid.
// The three 35-bit ramp products (one per channel) set the stage depth.
// Reset (rst_n low, asynchronous) empties the pipeline, the output register
// and the skid slot; payload registers keep whatever they hold.
// Stall: when rgb_out is held, one more result parks in the skid slot and
// hsl_in.ready drops the next cycle; the pipeline freezes without loss.
module hsl_to_rgb import h2r_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    hsl_in_if.sink      hsl_in,
    rgb_out_if.source   rgb_out
);

    localparam int NUM_ST = 5;

    function automatic fx_t clamp_one(fx_t v);
        return (v > ONE) ? ONE : v;
    endfunction

    // Six times a narrow value, kept in the field width (caller bounds it)
    function automatic fx_t times_six(fx_t v);
        logic [FIELD_W+1:0] acc;
        acc = {v, 2'b00} + {1'b0, v, 1'b0};
        return acc[FIELD_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Flow control
    // ---------------------------------------------------------------
    logic              skid_full_reg, skid_full_next;
    logic              out_valid_reg, out_valid_next;
    logic [NUM_ST-1:0] stage_v_reg;
    logic              adv;
    logic              arriving;
    logic              out_free;
    logic              load_from_skid, load_from_pipe, load_skid;

    // The whole pipeline moves together; it freezes only while the skid slot
    // is occupied, so the ready path back to hsl_in is a single flop.
    assign adv           = ~skid_full_reg;
    assign hsl_in.ready  = adv;
    assign arriving      = adv & stage_v_reg[NUM_ST-1];
    assign out_free      = ~out_valid_reg | rgb_out.ready;

    assign load_from_skid = out_free & skid_full_reg;
    assign load_from_pipe = out_free & ~skid_full_reg & arriving;
    assign load_skid      = ~out_free & arriving;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        if (out_free)
        begin
            if (skid_full_reg)
            begin
                out_valid_next = 1'b1;
                skid_full_next = 1'b0;
            end
            else
            begin
                out_valid_next = arriving;
            end
        end
        else if (arriving)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg   <= '0;
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                stage_v_reg <= {stage_v_reg[NUM_ST-2:0], hsl_in.valid};
            end
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: clamp inputs to 1.0
    // ---------------------------------------------------------------
    fx_t h1_reg, s1_reg, l1_reg;

    // ---------------------------------------------------------------
    // Stage 2: l*s product, hue shifted and wrapped per channel
    // ---------------------------------------------------------------
    logic [2*FIELD_W-1:0] ls_full;
    q_t                   hue_plus;
    fx_t                  t2_next [NUM_CH];
    fx_t                  l2_reg, s2_reg, ls2_reg;
    fx_t                  t2_reg [NUM_CH];

    assign ls_full  = {{FIELD_W{1'b0}}, l1_reg} * {{FIELD_W{1'b0}}, s1_reg};
    assign hue_plus = {1'b0, h1_reg} + {1'b0, THIRD};

    always_comb
    begin
        // red: hue + 1/3, wrapped down past one turn
        if (hue_plus > {1'b0, ONE})
        begin
            t2_next[0] = fx_t'(hue_plus - {1'b0, ONE});
        end
        else
        begin
            t2_next[0] = fx_t'(hue_plus);
        end
        t2_next[1] = h1_reg;
        // blue: hue - 1/3, wrapped up below zero
        if (h1_reg < THIRD)
        begin
            t2_next[2] = h1_reg + (ONE - THIRD);
        end
        else
        begin
            t2_next[2] = h1_reg - THIRD;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: q and p, ramp piece and ramp slope factor per channel
    // ---------------------------------------------------------------
    q_t          q3_next;
    logic [Q_W:0] two_l;
    fx_t         p3_next;
    seg_t        seg3_next [NUM_CH];
    fx_t         u3_next [NUM_CH];
    q_t          q3_reg;
    fx_t         p3_reg;
    seg_t        seg3_reg [NUM_CH];
    fx_t         u3_reg [NUM_CH];

    always_comb
    begin
        if (l2_reg < HALF)
        begin
            q3_next = {1'b0, l2_reg} + {1'b0, ls2_reg};
        end
        else
        begin
            q3_next = {1'b0, l2_reg} + {1'b0, s2_reg} - {1'b0, ls2_reg};
        end
        two_l = {1'b0, l2_reg, 1'b0};
        // p = 2l - q, floored at zero
        if (two_l < {1'b0, q3_next})
        begin
            p3_next = '0;
        end
        else
        begin
            p3_next = fx_t'(two_l - {1'b0, q3_next});
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (t2_reg[c] < SIXTH)
            begin
                seg3_next[c] = SEG_RISE;
                u3_next[c]   = times_six(t2_reg[c]);
            end
            else if (t2_reg[c] < HALF)
            begin
                seg3_next[c] = SEG_PLAT;
                u3_next[c]   = '0;
            end
            else if (t2_reg[c] < TWO_THIRDS)
            begin
                seg3_next[c] = SEG_FALL;
                u3_next[c]   = times_six(TWO_THIRDS - t2_reg[c]);
            end
            else
            begin
                seg3_next[c] = SEG_FLOOR;
                u3_next[c]   = '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: d = q - p
    // ---------------------------------------------------------------
    q_t   d4_next;
    q_t   d4_reg, q4_reg;
    fx_t  p4_reg;
    seg_t seg4_reg [NUM_CH];
    fx_t  u4_reg [NUM_CH];

    always_comb
    begin
        if (q3_reg < {1'b0, p3_reg})
        begin
            d4_next = '0;
        end
        else
        begin
            d4_next = q3_reg - {1'b0, p3_reg};
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: ramp products, truncated
    // ---------------------------------------------------------------
    logic [PROD_W-1:0] prod [NUM_CH];
    logic [RAMP_W-1:0] ramp5_reg [NUM_CH];
    q_t                q5_reg;
    fx_t               p5_reg;
    seg_t              seg5_reg [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod[c] = {{FIELD_W{1'b0}}, d4_reg} * {{Q_W{1'b0}}, u4_reg[c]};
        end
    end

    // ---------------------------------------------------------------
    // Output select
    // ---------------------------------------------------------------
    logic [RAMP_W:0] ramp_sum [NUM_CH];
    fx_t             res [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            ramp_sum[c] = {{(RAMP_W + 1 - FIELD_W){1'b0}}, p5_reg}
                          + {1'b0, ramp5_reg[c]};
            case (seg5_reg[c])
                SEG_RISE:  res[c] = ramp_sum[c][FIELD_W-1:0];
                SEG_FALL:  res[c] = ramp_sum[c][FIELD_W-1:0];
                SEG_PLAT:  res[c] = q5_reg[FIELD_W-1:0];
                SEG_FLOOR: res[c] = p5_reg;
                default:   res[c] = p5_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Payload registers (no reset)
    // ---------------------------------------------------------------
    fx_t out_reg [NUM_CH];
    fx_t skid_reg [NUM_CH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_reg  <= clamp_one(hsl_in.hue);
            s1_reg  <= clamp_one(hsl_in.saturation);
            l1_reg  <= clamp_one(hsl_in.lightness);

            l2_reg  <= l1_reg;
            s2_reg  <= s1_reg;
            ls2_reg <= ls_full[FRAC_BITS +: FIELD_W];

            q3_reg  <= q3_next;
            p3_reg  <= p3_next;

            d4_reg  <= d4_next;
            q4_reg  <= q3_reg;
            p4_reg  <= p3_reg;

            q5_reg  <= q4_reg;
            p5_reg  <= p4_reg;

            for (int c = 0; c < NUM_CH; c++)
            begin
                t2_reg[c]    <= t2_next[c];
                seg3_reg[c]  <= seg3_next[c];
                u3_reg[c]    <= u3_next[c];
                seg4_reg[c]  <= seg3_reg[c];
                u4_reg[c]    <= u3_reg[c];
                seg5_reg[c]  <= seg4_reg[c];
                ramp5_reg[c] <= prod[c][PROD_W-1:FRAC_BITS];
            end
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (load_from_skid)
            begin
                out_reg[c] <= skid_reg[c];
            end
            else if (load_from_pipe)
            begin
                out_reg[c] <= res[c];
            end
            if (load_skid)
            begin
                skid_reg[c] <= res[c];
            end
        end
    end

    assign rgb_out.valid = out_valid_reg;
    assign rgb_out.red   = out_reg[0];
    assign rgb_out.green = out_reg[1];
    assign rgb_out.blue  = out_reg[2];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid slot occupied while output register empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(out_valid_reg && !rgb_out.ready
                                       && stage_v_reg[NUM_ST-1]))
        else $error("skid slot filled without a held output and an arriving result");

    a_p_not_above_q: assert property (@(posedge clk) disable iff (!rst_n)
        stage_v_reg[NUM_ST-1] |-> ({1'b0, p5_reg} <= q5_reg))
        else $error("ramp floor p above ramp top q");

    a_slope_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stage_v_reg[3] |-> (u4_reg[0] <= U_MAX && u4_reg[1] <= U_MAX
                            && u4_reg[2] <= U_MAX))
        else $error("ramp slope factor out of range");

endmodule

>>> tb/hsl_to_rgb_test.sv
`timescale 1ns / 100ps

module hsl_to_rgb_test import h2r_pkg::*; ();

    // Run-length knobs. The run is short by nature: one pixel per clock at best,
    // and the long stalls of the output pattern below slow it further.
    localparam int N_DIRECTED     = 22;
    localparam int N_RANDOM       = 550;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 12;  // keep a margin past the pipeline latency

    // Signed 64-bit copies of the fixed-point breakpoints. Mixing these with
    // the unsigned package constants would turn comparisons unsigned.
    localparam longint UNIT_L   = ONE;
    localparam longint THIRD_L  = THIRD;
    localparam longint SIXTH_L  = SIXTH;
    localparam longint HALF_L   = HALF;
    localparam longint TWO3RD_L = TWO_THIRDS;

    typedef struct packed {
        fx_t hue;
        fx_t saturation;
        fx_t lightness;
    } hsl_t;

    typedef struct packed {
        fx_t red;
        fx_t green;
        fx_t blue;
    } rgb_t;

    // One row of the directed walk. Where pinned is set, the color is typed in
    // here; otherwise it comes from the color predictor.
    typedef struct packed {
        hsl_t px;
        bit   pinned;
        rgb_t color;
    } pixel_row_t;

    logic clk;
    logic rst_n;

    hsl_in_if  hsl_in();
    rgb_out_if rgb_out();

    hsl_to_rgb u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .hsl_in  (hsl_in),
        .rgb_out (rgb_out)
    );

    rgb_t       expected_rgb [$];
    pixel_row_t directed_rows [N_DIRECTED];
    int         fail_count;
    int         cycle_count;

    // ------------------------------------------------------------------
    // Clock, cycle counter, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // A hung pipeline or a lost transfer ends up here.
    initial
    begin
        wait (cycle_count >= TIMEOUT_CYCLES);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Color predictor
    // ------------------------------------------------------------------

    // Clamp an input field to 1.0.
    function automatic longint clamp_unit(fx_t v);
        longint w;
        w = longint'(v);
        return (w > UNIT_L) ? UNIT_L : w;
    endfunction

    // Evaluate the piecewise ramp between floor p and peak q at shifted hue t.
    function automatic fx_t ramp_level(longint t, longint p, longint q);
        longint d;
        longint r;
        d = q - p;
        // wrap the shifted hue back into the turn; exactly 1.0 stays put
        if (t < 0)
            t = t + UNIT_L;
        if (t > UNIT_L)
            t = t - UNIT_L;
        if (t < 0)
            t = 0;
        if (d < 0)
            d = 0;

        if (t < SIXTH_L)
            r = p + ((d * 6 * t) >> FRAC_BITS);
        else if (t < HALF_L)
            r = q;
        else if (t < TWO3RD_L)
            r = p + ((d * 6 * (TWO3RD_L - t)) >> FRAC_BITS);
        else
            r = p;

        if (r < 0)
            r = 0;
        return fx_t'(r);
    endfunction

    function automatic rgb_t predict_rgb(hsl_t px);
        longint h;
        longint s;
        longint l;
        longint ls;
        longint q;
        longint p;
        rgb_t   c;
        h  = clamp_unit(px.hue);
        s  = clamp_unit(px.saturation);
        l  = clamp_unit(px.lightness);
        ls = (l * s) >> FRAC_BITS;
        if (l < HALF_L)
            q = l + ls;
        else
            q = l + s - ls;
        p = 2 * l - q;
        if (p < 0)
            p = 0;
        c.red   = ramp_level(h + THIRD_L, p, q);
        c.green = ramp_level(h, p, q);
        c.blue  = ramp_level(h - THIRD_L, p, q);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Random field generators
    // ------------------------------------------------------------------

    // Saturation or lightness: mostly in range, some clamped, some corners.
    function automatic fx_t pick_level();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return fx_t'($urandom_range(0, ONE));
        if (sel < 82)
            return fx_t'($urandom_range(ONE + 1, 17'h1FFFF));
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ONE;
            2:       return HALF - 1;
            3:       return HALF;
            4:       return fx_t'(1);
            default: return ONE - 1;
        endcase
    endfunction

    // Hue: a good share lands within two LSBs of a ramp breakpoint of some channel.
    function automatic fx_t pick_hue();
        int unsigned sel;
        longint      brk;
        longint      h;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return fx_t'($urandom_range(0, ONE));
        if (sel < 60)
            return fx_t'($urandom_range(ONE + 1, 17'h1FFFF));
        case ($urandom_range(0, 3))
            0:       brk = SIXTH_L;
            1:       brk = HALF_L;
            2:       brk = TWO3RD_L;
            default: brk = 0;
        endcase
        // pick which channel's shift lands on the breakpoint
        case ($urandom_range(0, 2))
            0:       h = brk - THIRD_L;
            1:       h = brk + THIRD_L;
            default: h = brk;
        endcase
        h = h + $urandom_range(0, 4) - 2;
        if (h < 0)
            h = h + UNIT_L;
        if (h > UNIT_L)
            h = h - UNIT_L;
        return fx_t'(h);
    endfunction

    function automatic hsl_t random_pixel();
        hsl_t px;
        px.hue        = pick_hue();
        px.saturation = pick_level();
        px.lightness  = pick_level();
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one pixel from the next falling edge and hold it until the
    // transfer; then log what should come out for it.
    task automatic send_pixel(hsl_t px, bit pinned, rgb_t pinned_color);
        @(negedge clk);
        hsl_in.valid      <= 1'b1;
        hsl_in.hue        <= px.hue;
        hsl_in.saturation <= px.saturation;
        hsl_in.lightness  <= px.lightness;
        do
            @(posedge clk);
        while (!hsl_in.ready);
        expected_rgb.insert(expected_rgb.size(),
                            pinned ? pinned_color : predict_rgb(px));
    endtask

    // Drop valid for a gap set by n; scramble the payload so that it is never
    // trusted while valid is low.
    task automatic idle_input(int n);
        @(negedge clk);
        hsl_in.valid      <= 1'b0;
        hsl_in.hue        <= fx_t'($urandom);
        hsl_in.saturation <= fx_t'($urandom);
        hsl_in.lightness  <= fx_t'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    // Hold off until every outstanding pixel has come back.
    task automatic drain_results();
        idle_input(1);
        while (expected_rgb.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern
    // ------------------------------------------------------------------
    // Periodically pick a mode: always ready, a fixed 3-of-4 pattern,
    // coin flips, or rare long stalls.
    int sink_mode;
    int sink_phase;
    int stall_left;

    initial
    begin
        sink_mode  = 0;
        sink_phase = 0;
        stall_left = 0;
    end

    always @(negedge clk)
    begin
        sink_phase = sink_phase + 1;
        if (sink_phase % 64 == 0)
            sink_mode = $urandom_range(0, 3);

        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rgb_out.ready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                0:       rgb_out.ready <= 1'b1;
                1:       rgb_out.ready <= (sink_phase % 4 != 3);
                2:       rgb_out.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(9, 29);
                        rgb_out.ready <= 1'b0;
                    end
                    else
                        rgb_out.ready <= 1'b1;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_rgb
        rgb_t want;
        if (rst_n && rgb_out.valid && rgb_out.ready)
        begin
            if (expected_rgb.size() == 0)
            begin
                $error("rgb_out: transfer with no pixel outstanding (%0d %0d %0d)",
                       rgb_out.red, rgb_out.green, rgb_out.blue);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = expected_rgb.pop_front();
                if (rgb_out.red !== want.red)
                begin
                    $error("red: expected %0d, got %0d", want.red, rgb_out.red);
                    fail_count = fail_count + 1;
                end
                if (rgb_out.green !== want.green)
                begin
                    $error("green: expected %0d, got %0d", want.green, rgb_out.green);
                    fail_count = fail_count + 1;
                end
                if (rgb_out.blue !== want.blue)
                begin
                    $error("blue: expected %0d, got %0d", want.blue, rgb_out.blue);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int sent;
        int burst;
        int k;

        fail_count        = 0;
        rst_n             = 1'b0;
        hsl_in.valid      = 1'b0;
        hsl_in.hue        = '0;
        hsl_in.saturation = '0;
        hsl_in.lightness  = '0;
        rgb_out.ready     = 1'b0;

        // Directed rows: hue, saturation, lightness, pinned, red, green, blue.
        // Pinned rows are the ones whose color is obvious: black, white,
        // grays (zero saturation gives lightness on every channel) and pure red.
        directed_rows = '{
            '{'{17'd0, 17'd0, 17'd0}, 1'b1, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd0, 17'd0, ONE}, 1'b1, '{ONE, ONE, ONE}},
            // every field above 1.0, clamped to white
            '{'{17'h1FFFF, 17'h1FFFF, 17'h1FFFF}, 1'b1, '{ONE, ONE, ONE}},
            '{'{17'd0, 17'd0, HALF}, 1'b1, '{HALF, HALF, HALF}},
            '{'{THIRD, 17'd0, fx_t'(HALF - 1)}, 1'b1,
              '{fx_t'(HALF - 1), fx_t'(HALF - 1), fx_t'(HALF - 1)}},
            '{'{17'd0, ONE, HALF}, 1'b1, '{ONE, 17'd0, 17'd0}},
            // hue at the end of the turn; red shift runs past 1.0
            '{'{ONE, ONE, HALF}, 1'b0, '0},
            '{'{17'h1FFFF, ONE, HALF}, 1'b0, '0},
            // either side of each ramp breakpoint on the green channel
            '{'{fx_t'(SIXTH - 1), ONE, HALF}, 1'b0, '0},
            '{'{SIXTH, ONE, HALF}, 1'b0, '0},
            '{'{fx_t'(HALF - 1), ONE, HALF}, 1'b0, '0},
            '{'{HALF, ONE, HALF}, 1'b0, '0},
            '{'{fx_t'(TWO_THIRDS - 1), ONE, HALF}, 1'b0, '0},
            '{'{TWO_THIRDS, ONE, HALF}, 1'b0, '0},
            // blue shift lands exactly on zero, then just below it
            '{'{THIRD, ONE, HALF}, 1'b0, '0},
            '{'{fx_t'(THIRD - 1), ONE, HALF}, 1'b0, '0},
            // red shift lands exactly on 1.0
            '{'{fx_t'(ONE - THIRD), ONE, HALF}, 1'b0, '0},
            '{'{17'h05555, ONE, fx_t'(HALF - 1)}, 1'b0, '0},
            '{'{17'h02000, 17'h1FFFF, 17'h04000}, 1'b0, '0},
            '{'{17'h09000, 17'h08000, 17'h0C000}, 1'b0, '0},
            '{'{17'h01000, ONE, 17'd1}, 1'b0, '0},
            '{'{17'h0E000, 17'd1, fx_t'(ONE - 1)}, 1'b0, '0}
        };

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed walk, with a few short gaps.
        for (k = 0; k < N_DIRECTED; k++)
        begin
            send_pixel(directed_rows[k].px, directed_rows[k].pinned,
                       directed_rows[k].color);
            if ($urandom_range(0, 2) == 0)
                idle_input($urandom_range(1, 3));
        end

        drain_results();

        // Random part: bursts of back-to-back pixels with random gaps.
        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && sent < N_RANDOM; k++)
            begin
                send_pixel(random_pixel(), 1'b0, '0);
                sent = sent + 1;
                // let the pipeline run fully dry once in the middle
                if (sent == N_RANDOM / 2)
                    drain_results();
            end
            if ($urandom_range(0, 3) != 0)
                idle_input($urandom_range(1, 8));
        end

        drain_results();
        // watch a little longer for stray transfers
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_rgb.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
